// ----- hw/rtl/qte_pkg.sv -----
// Package for the quaternion to Euler angle pipeline.
// Holds status codes, CORDIC angle table, fixed-point widths and constants.
// No dependencies.
package qte_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_READ_FAILED = 2'd1,
    STATUS_NO_QUAT     = 2'd2
  } status_t;

  localparam int TERM_W = 38;  // atan2 operand terms
  localparam int CV_W   = 41;  // CORDIC x and y
  localparam int Z_W    = 35;  // CORDIC angle, Q30 radians
  localparam int ISQ_W  = 62;  // square root remainder and root

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  localparam logic signed [TERM_W-1:0] Q30_ONE_T = 38'sd1073741824;
  localparam logic [ISQ_W-1:0]        ONE_SQ    = 62'h1000_0000_0000_0000;

  // degrees: floor((z * 573 + 81920) / 163840), split into >> 15 and / 5
  localparam logic signed [44:0] DEG_SCALE = 45'sd573;
  localparam logic signed [44:0] DEG_ROUND = 45'sd81920;
  localparam logic signed [44:0] DIV5_BIAS = 45'sd671088640;
  localparam logic signed [27:0] DIV5_BASE = 28'sd134217728;
  localparam logic [31:0]        DIV5_RECIP = 32'hCCCC_CCCD;

  localparam logic signed [27:0] LIM_PITCH = 28'sd5898677;
  localparam logic signed [27:0] LIM_WIDE  = 28'sd11797354;

  localparam logic signed [Z_W-1:0] ATAN_TAB [0:31] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
    35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
    35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
    35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
    35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
    35'sd1024,      35'sd512,       35'sd256,       35'sd128,
    35'sd64,        35'sd32,        35'sd16,        35'sd8,
    35'sd4,         35'sd2,         35'sd1,         35'sd0
  };

  typedef struct packed {
    status_t                  status;
    logic signed [31:0]       s;
    logic signed [TERM_W-1:0] ry;
    logic signed [TERM_W-1:0] rx;
    logic signed [TERM_W-1:0] wy;
    logic signed [TERM_W-1:0] wx;
  } carry_t;

  typedef struct packed {
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cvec_t;

endpackage

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Throughput: one quaternion per cycle; products, a 31-stage square root,
// three CORDIC lanes of CORDIC_STEPS stages and a 4-stage degree scaler.
// The whole pipeline holds when the output register is full and not taken.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// Depends on qte_pkg.
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic [1:0]   in_tuser,   // read_failed, quat_present
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // pitch_angle, roll_angle, yaw_angle, zero pad
  output logic [1:0]   out_tuser   // status_code
);

  localparam int ISQ_STEPS = 31;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: input register
  logic               s1_vld_r;
  logic signed [31:0] s1_q_r [4];
  status_t            s1_st_r;
  status_t            s1_st_nxt;

  always_comb begin
    priority if (in_tuser[0]) begin
      s1_st_nxt = STATUS_READ_FAILED;
    end else if (!in_tuser[1]) begin
      s1_st_nxt = STATUS_NO_QUAT;
    end else begin
      s1_st_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s1_q_r[j] <= in_tdata[32*j +: 32];
      end
      s1_st_r <= s1_st_nxt;
    end
  end

  // ---------------- stage 2: component products
  // order: ww xx yy zz wx wy wz xy xz yz
  logic               s2_vld_r;
  logic signed [63:0] s2_p_r [10];
  status_t            s2_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r[0] <= 64'(s1_q_r[0]) * 64'(s1_q_r[0]);
      s2_p_r[1] <= 64'(s1_q_r[1]) * 64'(s1_q_r[1]);
      s2_p_r[2] <= 64'(s1_q_r[2]) * 64'(s1_q_r[2]);
      s2_p_r[3] <= 64'(s1_q_r[3]) * 64'(s1_q_r[3]);
      s2_p_r[4] <= 64'(s1_q_r[0]) * 64'(s1_q_r[1]);
      s2_p_r[5] <= 64'(s1_q_r[0]) * 64'(s1_q_r[2]);
      s2_p_r[6] <= 64'(s1_q_r[0]) * 64'(s1_q_r[3]);
      s2_p_r[7] <= 64'(s1_q_r[1]) * 64'(s1_q_r[2]);
      s2_p_r[8] <= 64'(s1_q_r[1]) * 64'(s1_q_r[3]);
      s2_p_r[9] <= 64'(s1_q_r[2]) * 64'(s1_q_r[3]);
      s2_st_r   <= s1_st_r;
    end
  end

  // ---------------- stage 3: Q30 terms and asin argument clamp
  logic               s3_vld_r;
  carry_t             s3_c_r;
  carry_t             s3_c_nxt;
  logic signed [33:0] pq [10];
  logic signed [34:0] s_diff;
  logic signed [35:0] s_raw;
  logic signed [35:0] sum_r;
  logic signed [35:0] sum_x;
  logic signed [35:0] sum_w;
  logic signed [36:0] dbl_r;
  logic signed [36:0] dbl_x;
  logic signed [36:0] dbl_w;

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      pq[k] = 34'(s2_p_r[k] >>> 30);
    end
    s_diff = 35'(pq[5]) - 35'(pq[8]);
    s_raw  = {s_diff, 1'b0};
    sum_r  = 36'(pq[9]) + 36'(pq[4]);
    sum_x  = 36'(pq[1]) + 36'(pq[2]);
    sum_w  = 36'(pq[7]) + 36'(pq[6]);
    dbl_r  = {sum_r, 1'b0};
    dbl_x  = {sum_x, 1'b0};
    dbl_w  = {sum_w, 1'b0};
    s3_c_nxt.status = s2_st_r;
    priority if (s_raw > 36'sd1073741824) begin
      s3_c_nxt.s = 32'sd1073741824;
    end else if (s_raw < -36'sd1073741824) begin
      s3_c_nxt.s = -32'sd1073741824;
    end else begin
      s3_c_nxt.s = 32'(s_raw);
    end
    s3_c_nxt.ry = TERM_W'(dbl_r);
    s3_c_nxt.rx = Q30_ONE_T - TERM_W'(dbl_x);
    s3_c_nxt.wy = TERM_W'(dbl_w);
    s3_c_nxt.wx = TERM_W'(pq[0]) + TERM_W'(pq[1]) - TERM_W'(pq[2]) - TERM_W'(pq[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c_r <= s3_c_nxt;
    end
  end

  // ---------------- stage 4: s squared
  logic               s4_vld_r;
  logic signed [63:0] s4_ss_r;
  carry_t             s4_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ss_r <= 64'(s3_c_r.s) * 64'(s3_c_r.s);
      s4_c_r  <= s3_c_r;
    end
  end

  // ---------------- square root of 2^60 - s^2, one root bit per stage
  logic             isq_vld_r [0:ISQ_STEPS];
  logic [ISQ_W-1:0] isq_v_r   [0:ISQ_STEPS];
  logic [ISQ_W-1:0] isq_res_r [0:ISQ_STEPS];
  carry_t           isq_c_r   [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isq_vld_r[0] <= 1'b0;
    end else if (en) begin
      isq_vld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isq_v_r[0]   <= ONE_SQ - ISQ_W'(s4_ss_r);
      isq_res_r[0] <= '0;
      isq_c_r[0]   <= s4_c_r;
    end
  end

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (60 - 2*k);
    logic [ISQ_W-1:0] trial;
    logic [ISQ_W-1:0] v_nxt;
    logic [ISQ_W-1:0] res_nxt;

    always_comb begin
      trial = isq_res_r[k] + BIT;
      if (isq_v_r[k] >= trial) begin
        v_nxt   = isq_v_r[k] - trial;
        res_nxt = (isq_res_r[k] >> 1) + BIT;
      end else begin
        v_nxt   = isq_v_r[k];
        res_nxt = isq_res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        isq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        isq_vld_r[k+1] <= isq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        isq_v_r[k+1]   <= v_nxt;
        isq_res_r[k+1] <= res_nxt;
        isq_c_r[k+1]   <= isq_c_r[k];
      end
    end
  end

  // ---------------- CORDIC setup: lane 0 pitch, 1 roll, 2 yaw
  logic            cv_vld_r [0:CORDIC_STEPS];
  cvec_t           cv_r     [0:CORDIC_STEPS][3];
  logic [2:0]      cv_zero_r[0:CORDIC_STEPS];
  status_t         cv_st_r  [0:CORDIC_STEPS];
  logic signed [CV_W-1:0] py [3];
  logic signed [CV_W-1:0] px [3];
  cvec_t           prep_nxt [3];
  logic [2:0]      zero_nxt;

  always_comb begin
    py[0] = CV_W'(isq_c_r[ISQ_STEPS].s);
    px[0] = {10'b0, isq_res_r[ISQ_STEPS][30:0]};
    py[1] = CV_W'(isq_c_r[ISQ_STEPS].ry);
    px[1] = CV_W'(isq_c_r[ISQ_STEPS].rx);
    py[2] = CV_W'(isq_c_r[ISQ_STEPS].wy);
    px[2] = CV_W'(isq_c_r[ISQ_STEPS].wx);
    for (int l = 0; l < 3; l++) begin
      zero_nxt[l] = (px[l] == '0) && (py[l] == '0);
      if (px[l] < 0) begin
        prep_nxt[l].x = -px[l];
        prep_nxt[l].y = -py[l];
        prep_nxt[l].z = (py[l] >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        prep_nxt[l].x = px[l];
        prep_nxt[l].y = py[l];
        prep_nxt[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_vld_r[0] <= 1'b0;
    end else if (en) begin
      cv_vld_r[0] <= isq_vld_r[ISQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cv_r[0][l] <= prep_nxt[l];
      end
      cv_zero_r[0] <= zero_nxt;
      cv_st_r[0]   <= isq_c_r[ISQ_STEPS].status;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cvec_t step_nxt [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (cv_r[i][l].y >= 0) begin
          step_nxt[l].x = cv_r[i][l].x + (cv_r[i][l].y >>> i);
          step_nxt[l].y = cv_r[i][l].y - (cv_r[i][l].x >>> i);
          step_nxt[l].z = cv_r[i][l].z + ATAN_TAB[i];
        end else begin
          step_nxt[l].x = cv_r[i][l].x - (cv_r[i][l].y >>> i);
          step_nxt[l].y = cv_r[i][l].y + (cv_r[i][l].x >>> i);
          step_nxt[l].z = cv_r[i][l].z - ATAN_TAB[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_vld_r[i+1] <= cv_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          cv_r[i+1][l] <= step_nxt[l];
        end
        cv_zero_r[i+1] <= cv_zero_r[i];
        cv_st_r[i+1]   <= cv_st_r[i];
      end
    end
  end

  // ---------------- degree scaling
  logic               d1_vld_r, d2_vld_r, d3_vld_r, d4_vld_r;
  status_t            d1_st_r, d2_st_r, d3_st_r;
  logic signed [44:0] d1_pr_r [3];
  logic [29:0]        d2_m_r  [3];
  logic [61:0]        d3_q_r  [3];
  logic signed [44:0] zsel    [3];
  logic signed [44:0] d2_sh   [3];
  logic signed [27:0] ang     [3];
  logic signed [27:0] sat     [3];
  logic signed [27:0] lim     [3];
  logic [79:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  assign lim[0] = LIM_PITCH;
  assign lim[1] = LIM_WIDE;
  assign lim[2] = LIM_WIDE;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      // a zero vector has angle zero
      zsel[l]  = cv_zero_r[CORDIC_STEPS][l] ? '0 : 45'(cv_r[CORDIC_STEPS][l].z);
      d2_sh[l] = ((d1_pr_r[l] + DEG_ROUND) >>> 15) + DIV5_BIAS;
      ang[l]   = 28'(d3_q_r[l] >> 34) - DIV5_BASE;
      priority if (ang[l] > lim[l]) begin
        sat[l] = lim[l];
      end else if (ang[l] < -lim[l]) begin
        sat[l] = -lim[l];
      end else begin
        sat[l] = ang[l];
      end
      if (d3_st_r != STATUS_OK) begin
        sat[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
      d3_vld_r <= 1'b0;
      d4_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= cv_vld_r[CORDIC_STEPS];
      d2_vld_r <= d1_vld_r;
      d3_vld_r <= d2_vld_r;
      d4_vld_r <= d3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        d1_pr_r[l] <= zsel[l] * DEG_SCALE;
        d2_m_r[l]  <= 30'(d2_sh[l]);
        d3_q_r[l]  <= 62'(d2_m_r[l]) * 62'(DIV5_RECIP);
      end
      d1_st_r     <= cv_st_r[CORDIC_STEPS];
      d2_st_r     <= d1_st_r;
      d3_st_r     <= d2_st_r;
      out_tdata_r <= {6'b0, sat[2][24:0], sat[1][24:0], sat[0][23:0]};
      out_tuser_r <= d3_st_r;
    end
  end

  assign out_tvalid = d4_vld_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- hw/rtl/qte_checker.sv -----
// Port-level checks for the quaternion to Euler angle pipeline, and the bind
// that attaches them to the top level. Depends on qte_pkg.
module qte_checker
  import qte_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // angles are zero on any failure status
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STATUS_OK) |-> out_tdata == '0)
    else $error("nonzero angles with failure status");

  // input side advances whenever the result register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[23:0]) <= 24'sd5898677) &&
                   ($signed(out_tdata[23:0]) >= -24'sd5898677))
    else $error("pitch out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

// ----- tb/tb_quaternion_to_euler_angles.sv -----
// Testbench for quaternion_to_euler_angles: directed table, then random quaternions.
// Each result is compared with its table entry or with a local fixed-point Euler angle predictor.
// Depends on qte_pkg and the quaternion_to_euler_angles RTL.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  localparam int STEPS       = 24;
  localparam int N_RANDOM    = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 400;
  localparam int LATENCY     = 41 + STEPS;
  localparam longint Q1      = 64'sd1073741824;
  localparam longint PI_RAD  = 64'sd3373259426;

  typedef struct {
    logic [127:0] quat;
    logic [1:0]   flags;
    bit           typed;
    logic [79:0]  angles;
    status_t      status;
  } row_t;

  typedef struct packed {
    logic [79:0] angles;
    status_t     status;
  } euler_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
  logic [1:0]   in_tuser = '0;   // read_failed, quat_present
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;       // pitch_angle, roll_angle, yaw_angle, zero pad
  logic [1:0]   out_tuser;       // status_code

  euler_t pending_angles[$];
  int     mismatches = 0;
  int     cycles = 0;
  row_t   rows[$];

  always #5 clk = ~clk;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) DUT (.*);

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return floor_shift(a * b, 30);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_RAD : -PI_RAD;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint rad_to_deg(longint z, longint lim);
    longint n, r;
    n = z * 573 + 81920;
    r = (n >= 0) ? n / 163840 : -((-n + 163840 - 1) / 163840);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t euler_of(logic [127:0] q, logic [1:0] flags);
    euler_t e;
    longint w, x, y, z, s, c, pitch, roll, yaw;
    longint pww, pxx, pyy, pzz, pwx, pwy, pwz, pxy, pxz, pyz;
    w = longint'($signed(q[31:0]));
    x = longint'($signed(q[63:32]));
    y = longint'($signed(q[95:64]));
    z = longint'($signed(q[127:96]));
    pitch = 0;
    roll = 0;
    yaw = 0;
    if (flags[0]) begin
      e.status = STATUS_READ_FAILED;
    end else if (!flags[1]) begin
      e.status = STATUS_NO_QUAT;
    end else begin
      e.status = STATUS_OK;
      pww = mul_q30(w, w); pxx = mul_q30(x, x); pyy = mul_q30(y, y); pzz = mul_q30(z, z);
      pwx = mul_q30(w, x); pwy = mul_q30(w, y); pwz = mul_q30(w, z);
      pxy = mul_q30(x, y); pxz = mul_q30(x, z); pyz = mul_q30(y, z);
      s = 2 * (pwy - pxz);
      if (s > Q1) s = Q1;
      if (s < -Q1) s = -Q1;
      c = int_sqrt(longint'(Q1 * Q1 - s * s));
      pitch = rad_to_deg(vector_angle(s, c), 64'sd5898677);
      roll = rad_to_deg(vector_angle(2 * (pyz + pwx), Q1 - 2 * (pxx + pyy)), 64'sd11797354);
      yaw = rad_to_deg(vector_angle(2 * (pxy + pwz), pww + pxx - pyy - pzz), 64'sd11797354);
    end
    e.angles = {6'b0, yaw[24:0], roll[24:0], pitch[23:0]};
    return e;
  endfunction

  function automatic logic [31:0] pick_component(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h4000_0000;
          1: return 32'hC000_0000;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          4: return 32'h0;
          default: return 32'(int'($urandom_range(0, 64)) - 32);
        endcase
      end
    endcase
  endfunction

  function automatic logic [127:0] unit_quat();
    real v[4];
    real norm;
    logic [127:0] q;
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
      if ($urandom_range(0, 7) == 0) v[i] = 0.0;
      norm += v[i] * v[i];
    end
    if (norm == 0.0) return {96'b0, 32'h4000_0000};
    norm = $sqrt(norm);
    for (int i = 0; i < 4; i++) q[32*i +: 32] = 32'($rtoi(v[i] / norm * 1073741824.0));
    return q;
  endfunction

  task automatic add_row(logic [127:0] q, logic [1:0] f, bit typed, status_t st);
    row_t r;
    r.quat = q;
    r.flags = f;
    r.typed = typed;
    r.angles = '0;
    r.status = st;
    rows.push_back(r);
  endtask

  // receiver: long hold once, otherwise alternate full-rate and random stall stretches
  always @(posedge clk) begin
    euler_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.angles = out_tdata;
      got.status = status_t'(out_tuser);
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h %0d", got.angles, got.status);
      end else begin
        want = pending_angles.pop_front();
        if (got.angles[23:0] !== want.angles[23:0] || got.angles[48:24] !== want.angles[48:24]
            || got.angles[73:49] !== want.angles[73:49] || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %0d/%0d roll %0d/%0d yaw %0d/%0d status %0d/%0d",
                     $signed(want.angles[23:0]), $signed(got.angles[23:0]),
                     $signed(want.angles[48:24]), $signed(got.angles[48:24]),
                     $signed(want.angles[73:49]), $signed(got.angles[73:49]),
                     want.status, got.status);
        end
      end
    end
    if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_LEN)
      out_tready <= 1'b0;
    else if ((cycles / 200) % 3 == 0)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 99) < 60);
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t r;
    int burst, gap, drain;
    int mode;
    logic [127:0] q;
    logic [1:0] f;

    // status cases: angles forced to zero
    add_row({4{32'h4000_0000}}, 2'b11, 1'b1, STATUS_READ_FAILED);
    add_row({4{32'h4000_0000}}, 2'b01, 1'b1, STATUS_READ_FAILED);
    add_row({4{32'h4000_0000}}, 2'b00, 1'b1, STATUS_NO_QUAT);
    add_row({32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0}, 2'b00, 1'b1, STATUS_NO_QUAT);
    // identity, negated identity, pure x (roll at +pi), zero quaternion, pure y, pure z
    add_row({96'b0, 32'h4000_0000}, 2'b10, 1'b0, STATUS_OK);
    add_row({96'b0, 32'hC000_0000}, 2'b10, 1'b0, STATUS_OK);
    add_row({64'b0, 32'h4000_0000, 32'b0}, 2'b10, 1'b0, STATUS_OK);
    add_row('0, 2'b10, 1'b0, STATUS_OK);
    add_row({32'h0, 32'h4000_0000, 64'b0}, 2'b10, 1'b0, STATUS_OK);
    add_row({96'b0, 32'h4000_0000} << 96, 2'b10, 1'b0, STATUS_OK);
    // gimbal lock both ways and asin argument beyond one
    add_row({32'h0, 32'd759250125, 32'h0, 32'd759250125}, 2'b10, 1'b0, STATUS_OK);
    add_row({32'h0, 32'hD2BE_C333, 32'h0, 32'd759250125}, 2'b10, 1'b0, STATUS_OK);
    add_row({32'h0, 32'h4000_0000, 32'h0, 32'h4000_0000}, 2'b10, 1'b0, STATUS_OK);
    add_row({32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF}, 2'b10, 1'b0, STATUS_OK);
    // component extremes, saturation of the angles
    add_row({4{32'h7FFF_FFFF}}, 2'b10, 1'b0, STATUS_OK);
    add_row({4{32'h8000_0000}}, 2'b10, 1'b0, STATUS_OK);
    add_row({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 2'b10, 1'b0, STATUS_OK);
    add_row({4{32'hC000_0000}}, 2'b10, 1'b0, STATUS_OK);
    add_row({4{32'h2000_0000}}, 2'b10, 1'b0, STATUS_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    burst = 5;

    for (int n = 0; n < rows.size() + N_RANDOM; n++) begin
      if (n < rows.size()) begin
        r = rows[n];
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 6) q = unit_quat();
        else for (int i = 0; i < 4; i++) q[32*i +: 32] = pick_component(mode % 3);
        f = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        r.quat = q;
        r.flags = f;
        r.typed = 1'b0;
      end
      in_tvalid <= 1'b1;
      in_tdata <= r.quat;
      in_tuser <= r.flags;
      do @(posedge clk); while (!in_tready);
      if (r.typed) pending_angles.push_back('{angles: r.angles, status: r.status});
      else pending_angles.push_back(euler_of(r.quat, r.flags));
      burst--;
      if (burst <= 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0 && pending_angles.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
